// ----- rtl/alignment_stats_histogrammer_top_assert.svh -----
// Assertion macros for the alignment statistics histogrammer.
`ifndef ALIGNMENT_STATS_HISTOGRAMMER_TOP_ASSERT_SVH
`define ALIGNMENT_STATS_HISTOGRAMMER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define ASH_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ASH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASH_ASSERT_IMPL(lbl, ante, cons, msg)
`define ASH_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/ash_pkg.sv -----
// Shared types, constants and the saturating-increment function of the alignment statistics histogrammer.
`timescale 1ns / 1ps
package ash_pkg;
  localparam int unsigned EDIT_BINS_DEF    = 64;
  localparam int unsigned CORR_DIM_DEF     = 64;
  localparam int unsigned QUALITY_BINS_DEF = 256;
  localparam int unsigned NUM_SETS         = 3;
  localparam int unsigned NUM_OUTCOMES     = 5;
  localparam int unsigned IDX_W            = 16;
  localparam int unsigned EDIT_W           = 10;
  localparam int unsigned CNT_W            = 32;
  localparam int unsigned QUEUE_DEPTH      = 4;
  localparam int unsigned RESULT_DEPTH     = 4;

  localparam int unsigned OUT_MAPPED   = 0;
  localparam int unsigned OUT_UNIQUE   = 1;
  localparam int unsigned OUT_MULTIPLE = 2;
  localparam int unsigned OUT_AMBIG    = 3;
  localparam int unsigned OUT_UNAMBIG  = 4;

  localparam int unsigned FLG_BEST_PAIRED   = 0;
  localparam int unsigned FLG_SECOND_PAIRED = 1;
  localparam int unsigned FLG_ANCHOR_MATE2  = 2;
  localparam int unsigned FLG_ANCHOR_BEST   = 3;
  localparam int unsigned FLG_ANCHOR_SECOND = 4;
  localparam int unsigned FLG_ANCHOR_RC     = 5;
  localparam int unsigned FLG_OTHER_BEST    = 6;
  localparam int unsigned FLG_OTHER_SECOND  = 7;
  localparam int unsigned FLG_OTHER_RC      = 8;

  typedef enum logic [2:0] {
    TGT_NONE,
    TGT_TOTAL,
    TGT_OUTCOME,
    TGT_QUAL,
    TGT_EDIT,
    TGT_EDIT_RC,
    TGT_EDIT_NORC,
    TGT_CORR
  } tgt_e;

  typedef struct packed {
    logic              mapped;
    logic              multiple;
    logic              equal;
    logic              edit_ok;
    logic              rc;
    logic              corr_ok;
    logic [EDIT_W-1:0] edit;
    logic [IDX_W-1:0]  corr_idx;
  } upd_t;

  typedef struct packed {
    logic                     is_read;
    tgt_e                     tgt;
    logic [1:0]               rset;
    logic [IDX_W-1:0]         ridx;
    logic [7:0]               mapq;
    upd_t [NUM_SETS-1:0]      upd;
  } op_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
    return (x == '1) ? x : x + CNT_W'(1);
  endfunction
endpackage

// ----- rtl/alignment_stats_histogrammer_top.sv -----
// Top level of the alignment statistics histogrammer.
// Input side: an item is taken at a clock edge with push high and full low. Each item
// either records one read's alignment result (no result item) or reads one counter
// from the flat address map (one result item).
// Result side: while empty is low the oldest result is on counter_value_o; pop takes it.
// Throughput: one item per cycle while full is low. Each histogram store has its own memory
// per set, updated through a two-stage read-increment-write pipeline with forwarding.
// A read item's result is registered in the back end and then written into the result
// queue before it shows on the result side; before that the item may wait in the input queue.
// Reset: all counters return to zero. After reset a clearing sweep over addresses 0 to
// max(CORR_DIM*CORR_DIM, QUALITY_BINS, EDIT_BINS) - 1 (4095 by default) zeroes the
// memories; full stays high for that time.
// Stalls: read items are only sent to the counter stores when the result queue has
// room, so a stalled receiver backs up into the input queue and then raises full.
// Record items keep flowing while results wait, as long as no read is at the queue head.
`timescale 1ns / 1ps
`include "alignment_stats_histogrammer_top_assert.svh"
module alignment_stats_histogrammer_top #(
  parameter int unsigned EDIT_BINS    = ash_pkg::EDIT_BINS_DEF,
  parameter int unsigned CORR_DIM     = ash_pkg::CORR_DIM_DEF,
  parameter int unsigned QUALITY_BINS = ash_pkg::QUALITY_BINS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               action_i,
  input  logic [8:0]         flags_i,
  input  logic [7:0]         mapq_i,
  input  logic signed [15:0] anchor_best_score_i,
  input  logic signed [15:0] anchor_second_score_i,
  input  logic signed [15:0] other_best_score_i,
  input  logic signed [15:0] other_second_score_i,
  input  logic [9:0]         anchor_best_edits_i,
  input  logic [9:0]         anchor_second_edits_i,
  input  logic [9:0]         other_best_edits_i,
  input  logic [9:0]         other_second_edits_i,
  input  logic [13:0]        counter_address_i,
  output logic               empty,
  input  logic               pop,
  output logic [31:0]        counter_value_o
);
  import ash_pkg::*;

  localparam int unsigned D2    = CORR_DIM * CORR_DIM;
  localparam int unsigned MAXQE = (QUALITY_BINS > EDIT_BINS) ? QUALITY_BINS : EDIT_BINS;
  localparam int unsigned MAXD  = (D2 > MAXQE) ? D2 : MAXQE;
  localparam int unsigned CLR_W = $clog2(MAXD);
  localparam int unsigned OW    = $bits(op_t);
  localparam int unsigned RCW   = $clog2(RESULT_DEPTH + 1);

  op_t              front_op, head_op;
  logic [OW-1:0]    head_bits;
  logic             mid_full, mid_empty, issue;
  logic             clr_q;
  logic [CLR_W-1:0] clr_cnt_q;
  logic             res_vld;
  logic [CNT_W-1:0] res_val;
  logic             out_full;
  logic [RCW-1:0]   out_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      if (clr_cnt_q == CLR_W'(MAXD - 1)) begin
        clr_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + CLR_W'(1);
      end
    end
  end

  ash_front #(
    .EDIT_BINS(EDIT_BINS), .CORR_DIM(CORR_DIM), .QUALITY_BINS(QUALITY_BINS)
  ) u_front (
    .action_i, .flags_i, .mapq_i,
    .anchor_best_score_i, .anchor_second_score_i,
    .other_best_score_i, .other_second_score_i,
    .anchor_best_edits_i, .anchor_second_edits_i,
    .other_best_edits_i, .other_second_edits_i,
    .counter_address_i,
    .op_o (front_op)
  );

  ash_fifo #(.WIDTH(OW), .DEPTH(QUEUE_DEPTH)) u_mid_q (
    .clk_i, .rst_ni,
    .push_i  (push && !full),
    .data_i  (front_op),
    .full_o  (mid_full),
    .pop_i   (issue),
    .data_o  (head_bits),
    .empty_o (mid_empty),
    .count_o ()
  );

  assign head_op = op_t'(head_bits);
  assign full    = mid_full || clr_q;
  assign issue   = !mid_empty && !clr_q &&
                   (!head_op.is_read || (32'(out_count) + 32'(res_vld)) < RESULT_DEPTH);

  ash_back #(
    .EDIT_BINS(EDIT_BINS), .CORR_DIM(CORR_DIM), .QUALITY_BINS(QUALITY_BINS)
  ) u_back (
    .clk_i, .rst_ni,
    .issue_i    (issue),
    .op_i       (head_op),
    .clr_i      (clr_q),
    .clr_addr_i (IDX_W'(clr_cnt_q)),
    .res_vld_o  (res_vld),
    .res_val_o  (res_val)
  );

  ash_fifo #(.WIDTH(CNT_W), .DEPTH(RESULT_DEPTH)) u_out_q (
    .clk_i, .rst_ni,
    .push_i  (res_vld),
    .data_i  (res_val),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (counter_value_o),
    .empty_o (empty),
    .count_o (out_count)
  );

  `ASH_ASSERT_IMPL(a_full_in_clear, clr_q, full, "input side open during clearing sweep")
  `ASH_ASSERT_IMPL(a_no_issue_in_clear, issue, !clr_q, "item issued during clearing sweep")
  `ASH_ASSERT_IMPL(a_out_room, res_vld, !out_full, "result arrived with result queue full")
  `ASH_ASSERT_NEXT(a_read_returns, issue && head_op.is_read, res_vld, "read item gave no result")
endmodule

// ----- rtl/ash_fifo.sv -----
// Small register queue with push/full and pop/empty sides and an occupancy count.
`timescale 1ns / 1ps
module ash_fifo #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             data_i,
  output logic                         full_o,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             data_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end
endmodule

// ----- rtl/ash_front.sv -----
// Front end: classifies one item into counter updates per set or a decoded counter read.
`timescale 1ns / 1ps
module ash_front #(
  parameter int unsigned EDIT_BINS    = ash_pkg::EDIT_BINS_DEF,
  parameter int unsigned CORR_DIM     = ash_pkg::CORR_DIM_DEF,
  parameter int unsigned QUALITY_BINS = ash_pkg::QUALITY_BINS_DEF
) (
  input  logic               action_i,
  input  logic [8:0]         flags_i,
  input  logic [7:0]         mapq_i,
  input  logic signed [15:0] anchor_best_score_i,
  input  logic signed [15:0] anchor_second_score_i,
  input  logic signed [15:0] other_best_score_i,
  input  logic signed [15:0] other_second_score_i,
  input  logic [9:0]         anchor_best_edits_i,
  input  logic [9:0]         anchor_second_edits_i,
  input  logic [9:0]         other_best_edits_i,
  input  logic [9:0]         other_second_edits_i,
  input  logic [13:0]        counter_address_i,
  output ash_pkg::op_t       op_o
);
  import ash_pkg::*;

  localparam int unsigned D2   = CORR_DIM * CORR_DIM;
  localparam int unsigned QB   = 1 + NUM_SETS * NUM_OUTCOMES;
  localparam int unsigned EB   = QB + NUM_SETS * QUALITY_BINS;
  localparam int unsigned ERB  = EB + NUM_SETS * EDIT_BINS;
  localparam int unsigned ENB  = ERB + NUM_SETS * EDIT_BINS;
  localparam int unsigned CB   = ENB + NUM_SETS * EDIT_BINS;
  localparam int unsigned ENDA = CB + NUM_SETS * D2;

  typedef struct packed {
    logic [1:0]       set;
    logic [IDX_W-1:0] idx;
  } loc_t;

  function automatic loc_t split(input logic [31:0] off, input int unsigned n);
    loc_t l;
    if (off < n) begin
      l.set = 2'd0;
      l.idx = IDX_W'(off);
    end else if (off < 2 * n) begin
      l.set = 2'd1;
      l.idx = IDX_W'(off - n);
    end else begin
      l.set = 2'd2;
      l.idx = IDX_W'(off - 2 * n);
    end
    return l;
  endfunction

  function automatic upd_t mapped_upd(input logic multiple, input logic rc,
                                      input logic signed [16:0] first,
                                      input logic signed [16:0] second,
                                      input logic [10:0] fe, input logic [10:0] se);
    upd_t             u;
    logic [11:0]      fe1, se1;
    logic [IDX_W-1:0] col;
    u          = '0;
    fe1        = {1'b0, fe} + 12'd1;
    se1        = {1'b0, se} + 12'd1;
    u.mapped   = 1'b1;
    u.multiple = multiple;
    u.equal    = (first == second);
    u.rc       = rc;
    u.edit_ok  = multiple && (32'(fe) < EDIT_BINS);
    u.edit     = fe[EDIT_W-1:0];
    u.corr_ok  = multiple && (32'(fe1) < CORR_DIM);
    col        = (32'(se1) < CORR_DIM) ? IDX_W'(se1) : '0;
    u.corr_idx = IDX_W'(32'(fe1) * CORR_DIM + 32'(col));
    return u;
  endfunction

  function automatic upd_t mate_upd(input logic best_al, input logic second_al,
                                    input logic rc,
                                    input logic signed [15:0] bs,
                                    input logic signed [15:0] ss,
                                    input logic [9:0] be, input logic [9:0] se);
    upd_t u;
    if (best_al) begin
      u = mapped_upd(second_al, rc, 17'(bs), 17'(ss), {1'b0, be}, {1'b0, se});
    end else begin
      u         = '0;
      u.corr_ok = 1'b1;
    end
    return u;
  endfunction

  logic [31:0] addr;
  loc_t        loc;
  upd_t        anchor_u, other_u;

  always_comb begin
    addr     = 32'(counter_address_i);
    op_o     = '0;
    loc      = '0;
    anchor_u = mate_upd(flags_i[FLG_ANCHOR_BEST], flags_i[FLG_ANCHOR_SECOND],
                        flags_i[FLG_ANCHOR_RC], anchor_best_score_i,
                        anchor_second_score_i, anchor_best_edits_i,
                        anchor_second_edits_i);
    other_u  = mate_upd(flags_i[FLG_OTHER_BEST], flags_i[FLG_OTHER_SECOND],
                        flags_i[FLG_OTHER_RC], other_best_score_i,
                        other_second_score_i, other_best_edits_i,
                        other_second_edits_i);
    op_o.is_read = action_i;
    op_o.mapq    = mapq_i;
    if (addr == 32'd0) begin
      op_o.tgt = TGT_TOTAL;
    end else if (addr < QB) begin
      op_o.tgt = TGT_OUTCOME;
      loc      = split(addr - 32'd1, NUM_OUTCOMES);
    end else if (addr < EB) begin
      op_o.tgt = TGT_QUAL;
      loc      = split(addr - QB, QUALITY_BINS);
    end else if (addr < ERB) begin
      op_o.tgt = TGT_EDIT;
      loc      = split(addr - EB, EDIT_BINS);
    end else if (addr < ENB) begin
      op_o.tgt = TGT_EDIT_RC;
      loc      = split(addr - ERB, EDIT_BINS);
    end else if (addr < CB) begin
      op_o.tgt = TGT_EDIT_NORC;
      loc      = split(addr - ENB, EDIT_BINS);
    end else if (addr < ENDA) begin
      op_o.tgt = TGT_CORR;
      loc      = split(addr - CB, D2);
    end else begin
      op_o.tgt = TGT_NONE;
    end
    op_o.rset = loc.set;
    op_o.ridx = loc.idx;
    if (flags_i[FLG_BEST_PAIRED]) begin
      op_o.upd[0] = mapped_upd(flags_i[FLG_SECOND_PAIRED], flags_i[FLG_ANCHOR_RC],
                               17'(anchor_best_score_i) + 17'(other_best_score_i),
                               17'(anchor_second_score_i) + 17'(other_second_score_i),
                               11'(anchor_best_edits_i) + 11'(other_best_edits_i),
                               11'(anchor_second_edits_i) + 11'(other_second_edits_i));
    end else if (flags_i[FLG_ANCHOR_MATE2]) begin
      op_o.upd[1] = other_u;
      op_o.upd[2] = anchor_u;
    end else begin
      op_o.upd[1] = anchor_u;
      op_o.upd[2] = other_u;
    end
  end
endmodule

// ----- rtl/ash_mem.sv -----
// One saturating counter memory with a read-increment-write pipeline and clear port.
`timescale 1ns / 1ps
module ash_mem #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clr_i,
  input  logic [ash_pkg::IDX_W-1:0]   clr_addr_i,
  input  logic                        inc_i,
  input  logic [ash_pkg::IDX_W-1:0]   addr_i,
  output logic [ash_pkg::CNT_W-1:0]   cnt_o
);
  import ash_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CNT_W-1:0] mem_q [DEPTH];
  logic [CNT_W-1:0] rdata_q, fwd_val_q, cur, nxt;
  logic [AW-1:0]    addr_q, fwd_addr_q;
  logic             inc_q, fwd_vld_q, clr_hit;

  assign cur     = (fwd_vld_q && fwd_addr_q == addr_q) ? fwd_val_q : rdata_q;
  assign nxt     = sat_inc(cur);
  assign cnt_o   = cur;
  assign clr_hit = clr_i && (32'(clr_addr_i) < DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q     <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      inc_q     <= inc_i;
      fwd_vld_q <= inc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_i[AW-1:0];
    rdata_q    <= mem_q[addr_i[AW-1:0]];
    fwd_addr_q <= addr_q;
    fwd_val_q  <= nxt;
    if (clr_hit) begin
      mem_q[clr_addr_i[AW-1:0]] <= '0;
    end else if (inc_q) begin
      mem_q[addr_q] <= nxt;
    end
  end
endmodule

// ----- rtl/ash_back.sv -----
// Back end: applies counter updates to the counter stores and returns counter reads.
`timescale 1ns / 1ps
module ash_back #(
  parameter int unsigned EDIT_BINS    = ash_pkg::EDIT_BINS_DEF,
  parameter int unsigned CORR_DIM     = ash_pkg::CORR_DIM_DEF,
  parameter int unsigned QUALITY_BINS = ash_pkg::QUALITY_BINS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      issue_i,
  input  ash_pkg::op_t              op_i,
  input  logic                      clr_i,
  input  logic [ash_pkg::IDX_W-1:0] clr_addr_i,
  output logic                      res_vld_o,
  output logic [ash_pkg::CNT_W-1:0] res_val_o
);
  import ash_pkg::*;

  logic [CNT_W-1:0] total_q;
  logic [CNT_W-1:0] outc_q [NUM_SETS][NUM_OUTCOMES];
  logic [CNT_W-1:0] flop_val, flop_q;
  logic             res_vld_q;
  tgt_e             tgt_q;
  logic [1:0]       rset_q;
  logic             rec;
  logic [CNT_W-1:0] qual_cnt [NUM_SETS];
  logic [CNT_W-1:0] eh_cnt [NUM_SETS];
  logic [CNT_W-1:0] ehrc_cnt [NUM_SETS];
  logic [CNT_W-1:0] ehnorc_cnt [NUM_SETS];
  logic [CNT_W-1:0] corr_cnt [NUM_SETS];

  assign rec = issue_i && !op_i.is_read;

  always_comb begin
    flop_val = '0;
    if (op_i.tgt == TGT_TOTAL) begin
      flop_val = total_q;
    end
    for (int s = 0; s < NUM_SETS; s++) begin
      for (int k = 0; k < NUM_OUTCOMES; k++) begin
        if (op_i.tgt == TGT_OUTCOME && op_i.rset == 2'(s) && op_i.ridx == IDX_W'(k)) begin
          flop_val = outc_q[s][k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      for (int s = 0; s < NUM_SETS; s++) begin
        for (int k = 0; k < NUM_OUTCOMES; k++) begin
          outc_q[s][k] <= '0;
        end
      end
    end else if (rec) begin
      total_q <= sat_inc(total_q);
      for (int s = 0; s < NUM_SETS; s++) begin
        if (op_i.upd[s].mapped) begin
          outc_q[s][OUT_MAPPED] <= sat_inc(outc_q[s][OUT_MAPPED]);
          if (op_i.upd[s].multiple) begin
            outc_q[s][OUT_MULTIPLE] <= sat_inc(outc_q[s][OUT_MULTIPLE]);
            if (op_i.upd[s].equal) begin
              outc_q[s][OUT_AMBIG] <= sat_inc(outc_q[s][OUT_AMBIG]);
            end else begin
              outc_q[s][OUT_UNAMBIG] <= sat_inc(outc_q[s][OUT_UNAMBIG]);
            end
          end else begin
            outc_q[s][OUT_UNIQUE] <= sat_inc(outc_q[s][OUT_UNIQUE]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= issue_i && op_i.is_read;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q  <= op_i.tgt;
    rset_q <= op_i.rset;
    flop_q <= flop_val;
  end

  for (genvar s = 0; s < NUM_SETS; s++) begin : g_set
    upd_t u;
    logic mh;
    assign u  = op_i.upd[s];
    assign mh = rec && u.mapped && u.multiple && u.edit_ok;

    ash_mem #(.DEPTH(QUALITY_BINS)) u_qual (
      .clk_i, .rst_ni, .clr_i, .clr_addr_i,
      .inc_i  (rec && u.mapped),
      .addr_i (op_i.is_read ? op_i.ridx : IDX_W'(op_i.mapq)),
      .cnt_o  (qual_cnt[s])
    );
    ash_mem #(.DEPTH(EDIT_BINS)) u_eh (
      .clk_i, .rst_ni, .clr_i, .clr_addr_i,
      .inc_i  (mh),
      .addr_i (op_i.is_read ? op_i.ridx : IDX_W'(u.edit)),
      .cnt_o  (eh_cnt[s])
    );
    ash_mem #(.DEPTH(EDIT_BINS)) u_ehrc (
      .clk_i, .rst_ni, .clr_i, .clr_addr_i,
      .inc_i  (mh && u.rc),
      .addr_i (op_i.is_read ? op_i.ridx : IDX_W'(u.edit)),
      .cnt_o  (ehrc_cnt[s])
    );
    ash_mem #(.DEPTH(EDIT_BINS)) u_ehnorc (
      .clk_i, .rst_ni, .clr_i, .clr_addr_i,
      .inc_i  (mh && !u.rc),
      .addr_i (op_i.is_read ? op_i.ridx : IDX_W'(u.edit)),
      .cnt_o  (ehnorc_cnt[s])
    );
    ash_mem #(.DEPTH(CORR_DIM * CORR_DIM)) u_corr (
      .clk_i, .rst_ni, .clr_i, .clr_addr_i,
      .inc_i  (rec && u.corr_ok),
      .addr_i (op_i.is_read ? op_i.ridx : u.corr_idx),
      .cnt_o  (corr_cnt[s])
    );
  end

  always_comb begin
    res_val_o = '0;
    for (int s = 0; s < NUM_SETS; s++) begin
      if (rset_q == 2'(s)) begin
        case (tgt_q)
          TGT_QUAL:      res_val_o = qual_cnt[s];
          TGT_EDIT:      res_val_o = eh_cnt[s];
          TGT_EDIT_RC:   res_val_o = ehrc_cnt[s];
          TGT_EDIT_NORC: res_val_o = ehnorc_cnt[s];
          TGT_CORR:      res_val_o = corr_cnt[s];
          default:       res_val_o = res_val_o;
        endcase
      end
    end
    case (tgt_q)
      TGT_TOTAL, TGT_OUTCOME: res_val_o = flop_q;
      TGT_NONE:               res_val_o = '0;
      default:                res_val_o = res_val_o;
    endcase
  end

  assign res_vld_o = res_vld_q;
endmodule
